@@ rtl/modbus_read_response_parser_unit_macros.svh @@
// Assertion macros used by the parser's top-level RTL file.
`ifndef MODBUS_READ_RESPONSE_PARSER_UNIT_MACROS_SVH
`define MODBUS_READ_RESPONSE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbrp_pkg.sv @@
// Types, constants and CRC function for the Modbus read response parser.
package mbrp_pkg;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  STATION_RESET     = 8'h01;

  typedef enum logic [2:0] {
    PH_HUNT      = 3'd0,
    PH_FUNC      = 3'd1,
    PH_COUNT     = 3'd2,
    PH_HIGH      = 3'd3,
    PH_LOW       = 3'd4,
    PH_CRC_A     = 3'd5,
    PH_CRC_B_OK  = 3'd6,
    PH_CRC_B_BAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EV_WORD     = 2'd0,
    EV_CRC_GOOD = 2'd1,
    EV_CRC_BAD  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [6:0]  index;
    logic [15:0] value;
  } result_t;

  // Reflected CRC-16/MODBUS, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mbrp_core.sv @@
// Frame state and per-byte parse logic of the Modbus read response parser.
module mbrp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              start_frame,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        station_address,
  output mbrp_pkg::result_t result
);

  mbrp_pkg::phase_t phase, phase_next, cur_phase;
  logic [7:0]  byte_count, byte_count_next, cur_count;
  logic [6:0]  word_position, word_position_next, cur_pos, pos_inc;
  logic [7:0]  pending_high_byte, pending_high_byte_next, cur_high;
  logic [15:0] crc_accumulator, crc_accumulator_next, cur_crc, crc_in, crc_fed;

  // Start flag clears the frame before this byte is taken.
  always_comb begin
    cur_phase = start_frame ? mbrp_pkg::PH_HUNT : phase;
    cur_count = start_frame ? 8'h00 : byte_count;
    cur_pos   = start_frame ? 7'h00 : word_position;
    cur_high  = start_frame ? 8'h00 : pending_high_byte;
    cur_crc   = start_frame ? mbrp_pkg::CRC_INIT : crc_accumulator;
    crc_in    = (cur_phase == mbrp_pkg::PH_HUNT) ? mbrp_pkg::CRC_INIT : cur_crc;
    crc_fed   = mbrp_pkg::crc_feed(crc_in, rx_byte);
    pos_inc   = cur_pos + 7'd1;
  end

  // Next state.
  always_comb begin
    phase_next             = cur_phase;
    byte_count_next        = cur_count;
    word_position_next     = cur_pos;
    pending_high_byte_next = cur_high;
    crc_accumulator_next   = cur_crc;
    case (cur_phase)
      mbrp_pkg::PH_HUNT: begin
        if (rx_byte == station_address) begin
          crc_accumulator_next = crc_fed;
          phase_next           = mbrp_pkg::PH_FUNC;
        end
      end
      mbrp_pkg::PH_FUNC: begin
        if (rx_byte == mbrp_pkg::FUNC_READ_HOLDING) begin
          crc_accumulator_next = crc_fed;
          phase_next           = mbrp_pkg::PH_COUNT;
        end else begin
          crc_accumulator_next = mbrp_pkg::CRC_INIT;
          phase_next           = mbrp_pkg::PH_HUNT;
        end
      end
      mbrp_pkg::PH_COUNT: begin
        byte_count_next      = rx_byte;
        word_position_next   = 7'h00;
        crc_accumulator_next = crc_fed;
        phase_next = (rx_byte[7:1] == 7'h00) ? mbrp_pkg::PH_CRC_A : mbrp_pkg::PH_HIGH;
      end
      mbrp_pkg::PH_HIGH: begin
        pending_high_byte_next = rx_byte;
        crc_accumulator_next   = crc_fed;
        phase_next             = mbrp_pkg::PH_LOW;
      end
      mbrp_pkg::PH_LOW: begin
        crc_accumulator_next = crc_fed;
        word_position_next   = pos_inc;
        phase_next = (pos_inc >= cur_count[7:1]) ? mbrp_pkg::PH_CRC_A : mbrp_pkg::PH_HIGH;
      end
      mbrp_pkg::PH_CRC_A: begin
        phase_next = (rx_byte == cur_crc[7:0]) ? mbrp_pkg::PH_CRC_B_OK
                                               : mbrp_pkg::PH_CRC_B_BAD;
      end
      mbrp_pkg::PH_CRC_B_OK, mbrp_pkg::PH_CRC_B_BAD: begin
        phase_next             = mbrp_pkg::PH_HUNT;
        byte_count_next        = 8'h00;
        word_position_next     = 7'h00;
        pending_high_byte_next = 8'h00;
        crc_accumulator_next   = mbrp_pkg::CRC_INIT;
      end
      default: begin
        phase_next = mbrp_pkg::PH_HUNT;
      end
    endcase
  end

  // Result for this byte.
  always_comb begin
    result.valid = 1'b0;
    result.kind  = mbrp_pkg::EV_WORD;
    result.index = 7'h00;
    result.value = 16'h0000;
    case (cur_phase)
      mbrp_pkg::PH_LOW: begin
        result.valid = 1'b1;
        result.index = cur_pos;
        result.value = {cur_high, rx_byte};
      end
      mbrp_pkg::PH_CRC_B_OK: begin
        result.valid = 1'b1;
        result.kind  = (rx_byte == cur_crc[15:8]) ? mbrp_pkg::EV_CRC_GOOD
                                                  : mbrp_pkg::EV_CRC_BAD;
      end
      mbrp_pkg::PH_CRC_B_BAD: begin
        result.valid = 1'b1;
        result.kind  = mbrp_pkg::EV_CRC_BAD;
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mbrp_pkg::PH_HUNT;
      byte_count        <= 8'h00;
      word_position     <= 7'h00;
      pending_high_byte <= 8'h00;
      crc_accumulator   <= mbrp_pkg::CRC_INIT;
    end else if (fire) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      word_position     <= word_position_next;
      pending_high_byte <= pending_high_byte_next;
      crc_accumulator   <= crc_accumulator_next;
    end
  end

endmodule

@@ rtl/modbus_read_response_parser_unit.sv @@
// Top level of the Modbus RTU function-3 reply parser.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one received byte per request
//   in rx_byte, with start_frame high to restart the parser at this byte.
//   Output channel (out_valid/out_ready) carries events: event_kind 0 is a
//   register word (reg_index, reg_value), 1 a frame with good CRC, 2 a frame
//   with a CRC error. Verdicts carry index and value of zero.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes station_address;
//   it is always ready and should be written only while the parser is idle.
// Timing:
//   One byte per cycle sustained while out_ready stays high. A byte is held in
//   the input register; the combinational byte-wide CRC update and phase step
//   then load the result register, from which an event shows on out_valid.
//   Bytes that cause no event simply pass through the input stage.
// Reset: clears the parser to address hunt, CRC to all ones, both stages
//   empty and station_address to 1.
// Stall: while out_ready is low with a result waiting, the input stage holds
//   its byte and in_ready drops once that stage is full; nothing is lost.
`include "modbus_read_response_parser_unit_macros.svh"

module modbus_read_response_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_frame,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [6:0]  reg_index,
  output logic [15:0] reg_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic              s1_valid;
  logic              s1_start;
  logic [7:0]        s1_byte;
  logic [7:0]        station_address;
  logic              advance;
  mbrp_pkg::result_t result;

  // Advance the held byte whenever the result register is free or draining.
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= mbrp_pkg::STATION_RESET;
    end else if (cfg_valid) begin
      station_address <= cfg_data;
    end
  end

  // Input register: take a new request, drop the stage once it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start <= start_frame;
      s1_byte  <= rx_byte;
    end
  end

  mbrp_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .start_frame     (s1_start),
    .rx_byte         (s1_byte),
    .station_address (station_address),
    .result          (result)
  );

  // Result register: load on advance, clear when taken with nothing behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      event_kind <= result.kind;
      reg_index  <= result.index;
      reg_value  <= result.value;
    end
  end

  `MBRP_ASSERT_NOW(a_no_overrun, clk, rst, in_valid && in_ready && s1_valid, !out_valid || out_ready, "input taken over a stalled stage")
  `MBRP_ASSERT_NEXT(a_result_loaded, clk, rst, advance && result.valid, out_valid, "parsed event not presented")
  `MBRP_ASSERT_NOW(a_verdict_zero, clk, rst, out_valid && (event_kind != mbrp_pkg::EV_WORD), (reg_index == 7'h00) && (reg_value == 16'h0000), "verdict with nonzero payload")

endmodule

@@ test/modbus_read_response_parser_unit_tb.sv @@
// Testbench for the Modbus RTU function-3 reply parser: directed replies, then random traffic.

module modbus_read_response_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrp_pkg::*;

  // One parser event as it is expected on the result channel.
  typedef struct {
    event_kind_t kind;
    logic [6:0]  index;
    logic [15:0] value;
  } parser_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        start_frame = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [6:0]  reg_index;
  logic [15:0] reg_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  // Shadow copy of the parser: its configuration and its state.
  logic [7:0]  shadow_station = STATION_RESET;
  phase_t      shadow_phase = PH_HUNT;
  logic [7:0]  shadow_count = 8'h00;
  logic [6:0]  shadow_word_pos = 7'd0;
  logic [7:0]  shadow_high = 8'h00;
  logic [15:0] shadow_crc = CRC_INIT;

  parser_event_t expected_events[$];

  int  error_count = 0;
  int  frame_bytes = 0;
  int  bytes_taken = 0;
  int  words_checked = 0;
  int  good_frames = 0;
  int  bad_frames = 0;
  // Set during a stretch where neither side may idle.
  bit  steady = 1'b0;

  modbus_read_response_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_frame(start_frame),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .reg_index(reg_index),
    .reg_value(reg_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Generous wall: the slowest legal run is far below this.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // CRC-16/MODBUS, reflected, one byte shifted in LSB first.
  function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      feedback = acc[0] ^ b[k];
      acc = acc >> 1;
      if (feedback) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Return the shadow parser to address hunt.
  function automatic void clear_shadow();
    shadow_phase = PH_HUNT;
    shadow_count = 8'h00;
    shadow_word_pos = 7'd0;
    shadow_high = 8'h00;
    shadow_crc = CRC_INIT;
  endfunction

  function automatic void push_event(input event_kind_t k, input logic [6:0] idx,
                                     input logic [15:0] val);
    parser_event_t ev;
    ev.kind = k;
    ev.index = idx;
    ev.value = val;
    expected_events.push_back(ev);
  endfunction

  // Advance the shadow parser by one accepted byte; queue the event it causes.
  function automatic void parse_byte(input logic restart, input logic [7:0] b);
    logic good;
    if (restart) begin
      clear_shadow();
    end
    case (shadow_phase)
      PH_HUNT: begin
        if (b == shadow_station) begin
          shadow_crc = fold_crc_byte(CRC_INIT, b);
          shadow_phase = PH_FUNC;
        end
      end
      PH_FUNC: begin
        // Anything but read-holding drops back to hunt; the byte is not reused.
        if (b == FUNC_READ_HOLDING) begin
          shadow_crc = fold_crc_byte(shadow_crc, b);
          shadow_phase = PH_COUNT;
        end else begin
          shadow_crc = CRC_INIT;
          shadow_phase = PH_HUNT;
        end
      end
      PH_COUNT: begin
        shadow_count = b;
        shadow_word_pos = 7'd0;
        shadow_crc = fold_crc_byte(shadow_crc, b);
        shadow_phase = (b[7:1] == 7'd0) ? PH_CRC_A : PH_HIGH;
      end
      PH_HIGH: begin
        shadow_high = b;
        shadow_crc = fold_crc_byte(shadow_crc, b);
        shadow_phase = PH_LOW;
      end
      PH_LOW: begin
        shadow_crc = fold_crc_byte(shadow_crc, b);
        push_event(EV_WORD, shadow_word_pos, {shadow_high, b});
        shadow_word_pos = shadow_word_pos + 7'd1;
        shadow_phase = (shadow_word_pos >= shadow_count[7:1]) ? PH_CRC_A : PH_HIGH;
      end
      PH_CRC_A: begin
        shadow_phase = (b == shadow_crc[7:0]) ? PH_CRC_B_OK : PH_CRC_B_BAD;
      end
      default: begin
        // Second CRC byte: a verdict always follows, then hunt again.
        good = (shadow_phase == PH_CRC_B_OK) && (b == shadow_crc[15:8]);
        push_event(good ? EV_CRC_GOOD : EV_CRC_BAD, 7'd0, 16'h0000);
        clear_shadow();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result side: check each accepted event against the oldest expectation,
  // and stall out_ready at random outside the steady stretch.
  always @(posedge clk) begin : check_events
    parser_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected event, kind", event_kind, 0);
      end else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind) begin
          report_mismatch("event_kind", event_kind, want.kind);
        end
        if (reg_index !== want.index) begin
          report_mismatch("reg_index", reg_index, want.index);
        end
        if (reg_value !== want.value) begin
          report_mismatch("reg_value", reg_value, want.value);
        end
        case (want.kind)
          EV_WORD:     words_checked++;
          EV_CRC_GOOD: good_frames++;
          default:     bad_frames++;
        endcase
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  // Send one byte request; hold it until taken, then advance the shadow parser.
  // Valid is lowered only in the idle cycles, so it is never dropped and raised
  // in the same step.
  task automatic offer_byte(input logic restart, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_frame <= restart;
    rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    bytes_taken++;
    parse_byte(restart, b);
  endtask

  // Hold the input and wait until every queued event is out, plus the pipeline depth
  // for bytes that raise no event.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic change_station(input logic [7:0] addr);
    drain_events();
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_station = addr;
    @(posedge clk);
  endtask

  // Build and send one reply. A function code other than read-holding ends the
  // reply after that byte. crc_fault: bit 0 spoils the low CRC byte, bit 1 the
  // high one. Only the first cut_at bytes go out.
  task automatic send_reply(input logic [7:0] addr, input logic [7:0] func, input int count,
                            input int crc_fault, input int cut_at, input logic restart);
    logic [7:0]  wire_bytes[$];
    logic [15:0] crc;
    wire_bytes.push_back(addr);
    wire_bytes.push_back(func);
    if (func == FUNC_READ_HOLDING) begin
      wire_bytes.push_back(count[7:0]);
      for (int i = 0; i < count; i++) begin
        case ($urandom_range(9))
          0:       wire_bytes.push_back(8'h00);
          1:       wire_bytes.push_back(8'hFF);
          default: wire_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
      crc = CRC_INIT;
      foreach (wire_bytes[i]) begin
        crc = fold_crc_byte(crc, wire_bytes[i]);
      end
      if (crc_fault[0]) begin
        crc[7:0] = crc[7:0] ^ (8'h01 << $urandom_range(7));
      end
      if (crc_fault[1]) begin
        crc[15:8] = crc[15:8] ^ (8'h01 << $urandom_range(7));
      end
      wire_bytes.push_back(crc[7:0]);
      wire_bytes.push_back(crc[15:8]);
    end
    for (int i = 0; i < wire_bytes.size() && i < cut_at; i++) begin
      offer_byte(restart && (i == 0), wire_bytes[i]);
      frame_bytes++;
    end
  endtask

  // A foreign byte ahead of a clean two-word reply with random words.
  task automatic test_basic_reply();
    offer_byte(1'b0, 8'h00);
    send_reply(STATION_RESET, FUNC_READ_HOLDING, 4, 0, 1000, 1'b0);
  endtask

  // A function code equal to the station address: drop to hunt, do not
  // take that byte as a new address.
  task automatic test_function_mismatch();
    send_reply(STATION_RESET, STATION_RESET, 0, 0, 1000, 1'b0);
  endtask

  // A one-byte count: no word, the odd data byte is read as the first CRC
  // byte, so the verdict is an error and the real high CRC byte is hunted over.
  task automatic test_short_counts();
    send_reply(STATION_RESET, FUNC_READ_HOLDING, 1, 0, 1000, 1'b0);
  endtask

  // Break a reply after one data byte and restart with the start flag on an
  // empty reply.
  task automatic test_start_restart();
    send_reply(STATION_RESET, FUNC_READ_HOLDING, 4, 0, 4, 1'b0);
    send_reply(STATION_RESET, FUNC_READ_HOLDING, 0, 0, 1000, 1'b1);
  endtask

  // The largest count: 127 words, indexes up to 126.
  task automatic test_long_reply();
    send_reply(shadow_station, FUNC_READ_HOLDING, 255, 0, 1000, 1'b1);
  endtask

  // Random replies with random content, among them foreign addresses, other
  // function codes, spoiled CRC, cut replies and line noise.
  task automatic test_random_replies(input int budget);
    int          stop_at;
    int          count;
    int          fault;
    int          cut;
    logic [7:0]  addr;
    logic [7:0]  func;
    stop_at = frame_bytes + budget;
    while (frame_bytes < stop_at) begin
      if ($urandom_range(99) < 10) begin
        offer_byte($urandom_range(99) < 5, 8'($urandom_range(255)));
      end else begin
        addr = ($urandom_range(99) < 90) ? shadow_station : 8'($urandom_range(255));
        func = ($urandom_range(99) < 90) ? FUNC_READ_HOLDING : 8'($urandom_range(255));
        count = ($urandom_range(99) < 70) ? $urandom_range(12) : $urandom_range(40);
        fault = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
        cut = ($urandom_range(99) < 10) ? $urandom_range(count + 4) : 1000;
        send_reply(addr, func, count, fault, cut, $urandom_range(99) < 80);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_reply();
    test_function_mismatch();
    test_short_counts();
    test_start_restart();

    // Station at its reset value, then sweep the address through its extremes.
    test_random_replies(80);
    change_station(8'h00);
    test_random_replies(120);
    change_station(8'hFF);
    test_long_reply();
    test_random_replies(100);
    // Address equal to the function code; both sides run without idling here.
    steady = 1'b1;
    change_station(FUNC_READ_HOLDING);
    test_random_replies(120);
    steady = 1'b0;
    change_station(8'($urandom_range(255)));
    test_random_replies(100);

    drain_events();
    repeat (10) @(posedge clk);

    $display("Took %0d bytes, %0d of them inside replies, across five station addresses.",
             bytes_taken, frame_bytes);
    $display("Checked %0d register words, %0d good and %0d failed CRC verdicts.",
             words_checked, good_frames, bad_frames);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
